[hw/rtl/fec_report_stats_tracker_macros.svh]
// Assertion macros shared by the FEC report statistics tracker modules.
`ifndef FEC_REPORT_STATS_TRACKER_MACROS_SVH
`define FEC_REPORT_STATS_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define FRST_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define FRST_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define FRST_ASSERT(label, clk, rst_n, prop)
`define FRST_ASSERT_NR(label, clk, prop)
`endif
`endif

[hw/rtl/frst_pkg.sv]
// Shared types and constants of the FEC report statistics tracker.
package frst_pkg;
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_LOSS = 2'd1;
  localparam logic [1:0] MODE_POLL = 2'd2;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_RATE_LIMITED = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  localparam logic [1:0] CFG_REPORT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LEN = 2'd1;
  localparam logic [1:0] CFG_FIRST_START = 2'd2;

  localparam int NWORDS = 15;

  // Command word handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_REPORT = 2'd0,
    CMD_LOSS   = 2'd1,
    CMD_POLL   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        feature;
    logic        len_ok;
    logic        fields_ok;
    logic        incomplete;
    logic        recovered;
    logic [15:0] miss;
    logic [15:0] rdata;
    logic [15:0] rpar;
    logic [15:0] lost;
    logic [31:0] now;
    logic [31:0] rtt;
    logic [31:0] rttv;
  } cmd_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

[hw/rtl/fec_report_stats_tracker.sv]
// Top level of the FEC report statistics tracker.
// Input words on in_*: mode 0 carries one report byte (tlast ends the report,
// tuser[0] is the feature flag), mode 1 a frame loss, mode 2 a poll with time
// and round trip figures. Each finished report gives one status word on out_*.
// A poll after the window has elapsed restarts the window and clears the counters;
// if a report or frame loss was counted, it also gives 15 snapshot words, one per cycle
// while out_tready is high, tlast on the fifteenth. An input word is taken every cycle
// unless the front's command register is held; a status word passes through that register
// and the output register after the final report byte. While a snapshot is sent out,
// the front keeps taking words until one of them needs the back, parks that one in its
// command register and then holds in_tready low until the snapshot words have left.
// When the receiver stalls the output register holds its word and the stall reaches the
// input after one command register. Configuration via cfg_* is taken at any cycle.
// Reset (rst_n low, synchronous) empties the pipeline, clears the counters and
// restores the register defaults; the report byte store is not cleared.
module fec_report_stats_tracker #(
  parameter int PAYLOAD_BYTES = 21,
  parameter int REPORT_LIMIT_MIN = 100,
  parameter int REPORT_LIMIT_MAX = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // mode, data_byte, now_ms, rtt_ms, rtt_var_ms, zero pad
  input  logic         in_tlast,
  input  logic         in_tuser,  // feature flag
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata, // ingest_status, word_index, word_value, zero pad
  output logic         out_tlast,
  output logic         out_tuser, // result_kind
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  logic           cmd_valid, cmd_ready;
  frst_pkg::cmd_t cmd;
  logic [1:0]     ostat;
  logic [3:0]     oidx;
  logic [31:0]    oval;

  assign cfg_ready = 1'b1;
  assign out_tdata = {2'b00, oval, oidx, ostat};

  frst_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .mode(in_tdata[1:0]), .data_byte(in_tdata[9:2]), .last_byte(in_tlast),
    .feature(in_tuser), .now(in_tdata[41:10]), .rtt(in_tdata[73:42]),
    .rttv(in_tdata[105:74]),
    .cmd_valid, .cmd_ready, .cmd
  );

  frst_back #(.REPORT_LIMIT_MIN(REPORT_LIMIT_MIN), .REPORT_LIMIT_MAX(REPORT_LIMIT_MAX)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .cfg_valid, .cfg_index, .cfg_data,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(ostat), .out_kind(out_tuser), .out_index(oidx), .out_value(oval),
    .out_last(out_tlast)
  );
endmodule

[hw/rtl/frst_front.sv]
// Front part: assembles and checks report bytes; forwards loss and poll words.
module frst_front #(
  parameter int PAYLOAD_BYTES = 21
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      mode,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  input  logic            feature,
  input  logic [31:0]     now,
  input  logic [31:0]     rtt,
  input  logic [31:0]     rttv,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output frst_pkg::cmd_t  cmd
);
  localparam int CW = $clog2(PAYLOAD_BYTES + 2);
  localparam int IW = $clog2(PAYLOAD_BYTES);

  logic [7:0]    bytes_r [PAYLOAD_BYTES];
  logic [CW-1:0] count_r, count_nxt;
  logic          cmd_valid_r;
  frst_pkg::cmd_t cmd_r, cmd_nxt;
  logic          fire, emit;

  logic [15:0] miss, tdata, tpar, rdata, rpar, total;
  logic [7:0]  pct, bidx, bcnt;
  logic [17:0] prod;
  logic [15:0] expect_par;
  logic [7:0]  last_b;
  logic        ok;

  assign in_ready = !cmd_valid_r || cmd_ready;
  assign fire = in_valid && in_ready;
  assign cmd_valid = cmd_valid_r;
  assign cmd = cmd_r;

  // Byte 20 is not yet stored while it is on the port, so it is taken from there.
  assign last_b = (count_r == CW'(20)) ? data_byte : bytes_r[20];
  assign miss  = {bytes_r[8], bytes_r[9]};
  assign tdata = {bytes_r[10], bytes_r[11]};
  assign tpar  = {bytes_r[12], bytes_r[13]};
  assign rdata = {bytes_r[14], bytes_r[15]};
  assign rpar  = {bytes_r[16], bytes_r[17]};
  assign pct   = bytes_r[18];
  assign bidx  = bytes_r[19];
  assign bcnt  = last_b;
  assign total = tdata + tpar;
  // Ceiling of tdata*pct/100; tdata is checked below 1024, so 18 bits cover it.
  assign prod = 18'(tdata[9:0] * pct) + 18'd99;
  assign expect_par = 16'((32'(prod) * 32'd5243) >> 19);

  always_comb begin
    ok = (total == 16'd0) ? (miss == 16'd0) : (miss < total);
    ok = ok && (tdata + tpar >= tdata) && rdata <= tdata && rpar <= tpar;
    ok = ok && tdata <= 16'h03FF && tpar == expect_par;
    ok = ok && (tdata != 16'd0 || pct == 8'd0);
    ok = ok && (pct == 8'd0 || total <= 16'd255);
    ok = ok && bcnt != 8'd0 && bcnt <= 8'd4 && bidx < bcnt;
  end

  always_comb begin
    count_nxt = count_r;
    emit = 1'b0;
    cmd_nxt = cmd_r;
    cmd_nxt.now = now;
    cmd_nxt.rtt = rtt;
    cmd_nxt.rttv = rttv;
    cmd_nxt.feature = feature;
    cmd_nxt.len_ok = (count_r == CW'(PAYLOAD_BYTES - 1));
    cmd_nxt.fields_ok = ok;
    cmd_nxt.incomplete = (tdata == 16'd0);
    cmd_nxt.recovered = ({1'b0, rdata} + {1'b0, rpar} >= {1'b0, tdata});
    cmd_nxt.miss = miss;
    cmd_nxt.rdata = rdata;
    cmd_nxt.rpar = rpar;
    cmd_nxt.lost = (tdata > rdata) ? tdata - rdata : 16'd0;
    case (mode)
      frst_pkg::MODE_BYTE: begin
        cmd_nxt.kind = frst_pkg::CMD_REPORT;
        if (last_byte) begin
          emit = 1'b1;
          count_nxt = '0;
        end else if (count_r <= CW'(PAYLOAD_BYTES)) begin
          count_nxt = count_r + CW'(1);
        end
      end
      frst_pkg::MODE_LOSS: begin
        cmd_nxt.kind = frst_pkg::CMD_LOSS;
        emit = 1'b1;
      end
      frst_pkg::MODE_POLL: begin
        cmd_nxt.kind = frst_pkg::CMD_POLL;
        emit = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cmd_valid_r <= 1'b0;
    end else begin
      if (fire) count_r <= count_nxt;
      if (fire) cmd_valid_r <= emit;
      else if (cmd_ready) cmd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) cmd_r <= cmd_nxt;
    if (fire && mode == frst_pkg::MODE_BYTE && count_r < CW'(PAYLOAD_BYTES))
      bytes_r[IW'(count_r)] <= data_byte;
  end

  `include "fec_report_stats_tracker_macros.svh"
  `FRST_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(PAYLOAD_BYTES + 1))
  `FRST_ASSERT(a_hold_stall, clk, rst_n, cmd_valid_r && !cmd_ready |=> cmd_valid_r && $stable(cmd_r))
  `FRST_ASSERT(a_no_ready_stall, clk, rst_n, cmd_valid_r && !cmd_ready |-> !in_ready)
endmodule

[hw/rtl/frst_back.sv]
// Back part: window counters, rate limit, snapshot capture and result output.
module frst_back #(
  parameter int REPORT_LIMIT_MIN = 100,
  parameter int REPORT_LIMIT_MAX = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  frst_pkg::cmd_t  cmd,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic            out_kind,
  output logic [3:0]      out_index,
  output logic [31:0]     out_value,
  output logic            out_last
);
  logic [15:0] limit_r, wlen_r;
  logic [31:0] wstart_r, seq_r;
  logic [31:0] cnt_r [12];
  logic [31:0] hold_r [frst_pkg::NWORDS];
  logic        busy_r;        // snapshot words still to go
  logic [3:0]  idx_r;
  logic        ov_r, okind_r, olast_r;
  logic [1:0]  ostat_r;
  logic [3:0]  oidx_r;
  logic [31:0] oval_r;
  logic [15:0] lim_used;
  logic [31:0] elapsed;
  logic        take, slot_free, lim_hit, active;
  logic [1:0]  st;

  assign lim_used = (limit_r < 16'(REPORT_LIMIT_MIN)) ? 16'(REPORT_LIMIT_MIN) :
                    (limit_r > 16'(REPORT_LIMIT_MAX)) ? 16'(REPORT_LIMIT_MAX) : limit_r;
  assign slot_free = !ov_r || out_ready;
  assign cmd_ready = !busy_r && slot_free;
  assign take = cmd_valid && cmd_ready;
  assign elapsed = cmd.now - wstart_r;
  assign lim_hit = cnt_r[0] >= {16'd0, lim_used};
  assign active = cnt_r[0] != 32'd0 || cnt_r[8] != 32'd0;

  always_comb begin
    if (lim_hit) st = frst_pkg::ST_RATE_LIMITED;
    else if (!cmd.feature) st = frst_pkg::ST_MISMATCH;
    else if (!cmd.len_ok || !cmd.fields_ok) st = frst_pkg::ST_MALFORMED;
    else st = frst_pkg::ST_ACCEPTED;
  end

  assign out_valid = ov_r;
  assign out_status = ostat_r;
  assign out_kind = okind_r;
  assign out_index = oidx_r;
  assign out_value = oval_r;
  assign out_last = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 16'd100;
      wlen_r <= 16'd1000;
      wstart_r <= '0;
      seq_r <= '0;
      busy_r <= 1'b0;
      idx_r <= '0;
      ov_r <= 1'b0;
      for (int i = 0; i < 12; i++) cnt_r[i] <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          frst_pkg::CFG_REPORT_LIMIT: limit_r <= cfg_data[15:0];
          frst_pkg::CFG_WINDOW_LEN:   wlen_r <= cfg_data[15:0];
          frst_pkg::CFG_FIRST_START:  wstart_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_ready) ov_r <= 1'b0;
      if (busy_r && slot_free) begin
        ov_r <= 1'b1;
        okind_r <= 1'b1;
        ostat_r <= frst_pkg::ST_ACCEPTED;
        oidx_r <= idx_r;
        oval_r <= hold_r[idx_r];
        olast_r <= (idx_r == 4'(frst_pkg::NWORDS - 1));
        idx_r <= idx_r + 4'd1;
        if (idx_r == 4'(frst_pkg::NWORDS - 1)) busy_r <= 1'b0;
      end
      if (take) begin
        case (cmd.kind)
          frst_pkg::CMD_REPORT: begin
            ov_r <= 1'b1;
            okind_r <= 1'b0;
            ostat_r <= st;
            oidx_r <= '0;
            oval_r <= '0;
            olast_r <= 1'b1;
            if (lim_hit) cnt_r[11] <= frst_pkg::sat_add(cnt_r[11], 32'd1);
            else begin
              cnt_r[0] <= frst_pkg::sat_add(cnt_r[0], 32'd1);
              if (st == frst_pkg::ST_MISMATCH)
                cnt_r[10] <= frst_pkg::sat_add(cnt_r[10], 32'd1);
              else if (st == frst_pkg::ST_MALFORMED)
                cnt_r[9] <= frst_pkg::sat_add(cnt_r[9], 32'd1);
              else begin
                cnt_r[1] <= frst_pkg::sat_add(cnt_r[1], 32'd1);
                if (cmd.incomplete) cnt_r[2] <= frst_pkg::sat_add(cnt_r[2], 32'd1);
                cnt_r[3] <= frst_pkg::sat_add(cnt_r[3], {16'd0, cmd.miss});
                cnt_r[5] <= frst_pkg::sat_add(cnt_r[5], {16'd0, cmd.rdata});
                cnt_r[6] <= frst_pkg::sat_add(cnt_r[6], {16'd0, cmd.rpar});
                if (cmd.recovered) cnt_r[7] <= frst_pkg::sat_add(cnt_r[7], {16'd0, cmd.lost});
                else cnt_r[4] <= frst_pkg::sat_add(cnt_r[4], {16'd0, cmd.lost});
              end
            end
          end
          frst_pkg::CMD_LOSS: cnt_r[8] <= frst_pkg::sat_add(cnt_r[8], 32'd1);
          frst_pkg::CMD_POLL: begin
            if (elapsed >= {16'd0, wlen_r}) begin
              wstart_r <= cmd.now;
              for (int i = 0; i < 12; i++) cnt_r[i] <= '0;
              if (active) begin
                seq_r <= seq_r + 32'd1;
                busy_r <= 1'b1;
                idx_r <= '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.kind == frst_pkg::CMD_POLL) begin
      hold_r[0] <= seq_r;
      hold_r[1] <= elapsed;
      hold_r[2] <= cnt_r[1];
      hold_r[3] <= cnt_r[2];
      hold_r[4] <= cnt_r[3];
      hold_r[5] <= cnt_r[4];
      hold_r[6] <= cnt_r[5];
      hold_r[7] <= cnt_r[6];
      hold_r[8] <= cnt_r[7];
      hold_r[9] <= cnt_r[8];
      hold_r[10] <= cnt_r[9];
      hold_r[11] <= cnt_r[10];
      hold_r[12] <= cnt_r[11];
      hold_r[13] <= cmd.rtt;
      hold_r[14] <= cmd.rttv;
    end
  end

  `include "fec_report_stats_tracker_macros.svh"
  `FRST_ASSERT(a_busy_blocks, clk, rst_n, busy_r |-> !cmd_ready)
  `FRST_ASSERT(a_idx_range, clk, rst_n, busy_r |-> idx_r <= 4'(frst_pkg::NWORDS - 1))
  `FRST_ASSERT(a_status_last, clk, rst_n, out_valid && !out_kind |-> out_last)
endmodule
